// File: hw/rtl/scbr_pkg.sv
// Shared types, codes and constants of the SCSI block command responder.
`timescale 1ns / 1ps
`default_nettype none
package scbr_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_DISK_SECTORS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECTOR_LOG2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEDIA_KIND = 2'd2;

  localparam logic [3:0] LOG2_MIN = 4'd9;
  localparam logic [3:0] LOG2_MAX = 4'd12;
  localparam logic [62:0] DISK_RESET = 63'd1;
  localparam logic [1:0] MEDIA_FIXED = 2'd1;

  localparam logic [2:0] REQ_EXECUTE = 3'd0;
  localparam logic [2:0] REQ_IOCTL = 3'd1;
  localparam logic [2:0] REQ_CLAIM = 3'd2;
  localparam logic [2:0] REQ_RELEASE = 3'd3;
  localparam logic [2:0] REQ_SHUTDOWN = 3'd4;
  localparam logic [2:0] REQ_FLUSH = 3'd5;

  localparam logic [7:0] OP_TEST_UNIT_READY = 8'h00;
  localparam logic [7:0] OP_MODE_SENSE = 8'h1A;
  localparam logic [7:0] OP_MEDIUM_REMOVAL = 8'h1E;
  localparam logic [7:0] OP_READ_CAPACITY = 8'h25;
  localparam logic [7:0] OP_READ10 = 8'h28;
  localparam logic [7:0] OP_WRITE10 = 8'h2A;
  localparam logic [7:0] OP_VERIFY10 = 8'h2F;
  localparam logic [7:0] OP_READ_TOC = 8'h43;
  localparam logic [7:0] OP_READ16 = 8'h88;
  localparam logic [7:0] OP_WRITE16 = 8'h8A;
  localparam logic [7:0] OP_VERIFY16 = 8'h8F;
  localparam logic [7:0] OP_READ_CAPACITY16 = 8'h9E;

  localparam logic [1:0] SRB_SUCCESS = 2'd0;
  localparam logic [1:0] SRB_INVALID = 2'd1;
  localparam logic [1:0] SRB_ERROR = 2'd2;
  localparam logic [1:0] SRB_OVERRUN = 2'd3;

  localparam logic [1:0] OPS_SUCCESS = 2'd0;
  localparam logic [1:0] OPS_NOT_IMPL = 2'd1;
  localparam logic [1:0] OPS_TOO_SMALL = 2'd2;

  localparam logic [1:0] IO_NONE = 2'd0;
  localparam logic [1:0] IO_READ = 2'd1;
  localparam logic [1:0] IO_WRITE = 2'd2;

  localparam logic [31:0] MODE_HDR_BYTES = 32'd4;
  localparam logic [31:0] TOC_BYTES = 32'd804;
  localparam logic [31:0] CAP10_BYTES = 32'd8;
  localparam logic [31:0] CAP16_BYTES = 32'd12;
  localparam logic [63:0] LBA32_MAX = 64'h0000_0000_ffff_ffff;

  typedef enum logic [3:0] {
    CLS_INVALID = 4'd0,
    CLS_NOT_IMPL = 4'd1,
    CLS_SUCCESS = 4'd2,
    CLS_BAD_OP = 4'd3,
    CLS_RW = 4'd4,
    CLS_CAP10 = 4'd5,
    CLS_CAP16 = 4'd6,
    CLS_MODE = 4'd7,
    CLS_TOC = 4'd8
  } cls_t;

  typedef struct packed {
    logic        valid;
    cls_t        cls;
    logic        is_read;
    logic [63:0] start;
    logic [31:0] count;
    logic        off_disk;
    logic [62:0] room;
    logic [31:0] buf_len;
    logic [3:0]  lg;
    logic [62:0] last;
    logic        fixed_disk;
  } dec_t;

  typedef struct packed {
    logic        valid;
    cls_t        cls;
    logic        is_read;
    logic [63:0] start;
    logic [31:0] count;
    logic [43:0] bytes;
    logic [31:0] buf_len;
    logic [3:0]  lg;
    logic [63:0] lba;
    logic        fixed_disk;
  } clip_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  srb_status;
    logic [1:0]  op_status;
    logic [1:0]  io_mode;
    logic [63:0] first_block;
    logic [31:0] block_count;
    logic [31:0] transfer_bytes;
    logic [31:0] info_bytes;
    logic [63:0] last_lba;
    logic [12:0] block_size;
    logic        medium_type;
  } res_t;

endpackage
`default_nettype wire

// File: hw/rtl/scbr_decode.sv
// First stage: request and opcode decode, LBA extraction and disk range check.
`timescale 1ns / 1ps
`default_nettype none
module scbr_decode (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  input  wire logic [2:0]   req_type,
  input  wire logic [7:0]   lun,
  input  wire logic [63:0]  cdb_head,
  input  wire logic [63:0]  cdb_tail,
  input  wire logic [31:0]  buffer_bytes,
  input  wire logic [62:0]  disk_sectors,
  input  wire logic [3:0]   sector_size_log2,
  input  wire logic [1:0]   media_kind,
  output scbr_pkg::dec_t    s1
);
  import scbr_pkg::*;

  dec_t        dec_next;
  logic [7:0]  op;
  logic [63:0] start_lba;
  logic [31:0] blocks;
  logic [64:0] diff;

  assign op = cdb_head[63:56];

  always_comb begin
    if (op == OP_READ16 || op == OP_WRITE16) begin
      start_lba = {cdb_head[47:0], cdb_tail[63:48]};
      blocks = cdb_tail[47:16];
    end else begin
      start_lba = {32'd0, cdb_head[47:16]};
      blocks = {16'd0, cdb_head[7:0], cdb_tail[63:56]};
    end
  end

  assign diff = {2'b00, disk_sectors} - {1'b0, start_lba};

  always_comb begin
    dec_next = '0;
    dec_next.valid = in_valid;
    dec_next.buf_len = buffer_bytes;
    dec_next.fixed_disk = (media_kind == MEDIA_FIXED);
    dec_next.last = (disk_sectors != '0) ? disk_sectors - 63'd1 : '0;
    if (sector_size_log2 < LOG2_MIN) begin
      dec_next.lg = LOG2_MIN;
    end else if (sector_size_log2 > LOG2_MAX) begin
      dec_next.lg = LOG2_MAX;
    end else begin
      dec_next.lg = sector_size_log2;
    end

    dec_next.start = start_lba;
    dec_next.count = blocks;
    dec_next.off_disk = diff[64] || (diff[63:0] == '0);
    dec_next.room = diff[62:0];
    dec_next.is_read = (op == OP_READ10 || op == OP_READ16);

    if (lun != 8'd0) begin
      dec_next.cls = CLS_INVALID;
    end else begin
      case (req_type)
        REQ_EXECUTE: begin
          case (op)
            OP_TEST_UNIT_READY, OP_VERIFY10, OP_VERIFY16, OP_MEDIUM_REMOVAL:
              dec_next.cls = CLS_SUCCESS;
            OP_READ10, OP_READ16, OP_WRITE10, OP_WRITE16: dec_next.cls = CLS_RW;
            OP_READ_CAPACITY: dec_next.cls = CLS_CAP10;
            OP_READ_CAPACITY16: dec_next.cls = CLS_CAP16;
            OP_MODE_SENSE: dec_next.cls = CLS_MODE;
            OP_READ_TOC: dec_next.cls = CLS_TOC;
            default: dec_next.cls = CLS_BAD_OP;
          endcase
        end
        REQ_IOCTL, REQ_CLAIM, REQ_RELEASE: dec_next.cls = CLS_INVALID;
        REQ_SHUTDOWN, REQ_FLUSH: dec_next.cls = CLS_SUCCESS;
        default: dec_next.cls = CLS_NOT_IMPL;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else begin
      s1 <= dec_next;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/scbr_clip.sv
// Second stage: clip the block count at the disk end and form the byte length.
`timescale 1ns / 1ps
`default_nettype none
module scbr_clip (
  input  wire logic      clk,
  input  wire logic      rst,
  input  scbr_pkg::dec_t s1,
  output scbr_pkg::clip_t s2
);
  import scbr_pkg::*;

  clip_t       clip_next;
  logic [31:0] count1;

  always_comb begin
    if (s1.off_disk) begin
      count1 = '0;
    end else if ({32'd0, s1.count} > {1'b0, s1.room}) begin
      count1 = s1.room[31:0];
    end else begin
      count1 = s1.count;
    end

    clip_next.valid = s1.valid;
    clip_next.cls = s1.cls;
    clip_next.is_read = s1.is_read;
    clip_next.start = s1.start;
    clip_next.count = count1;
    clip_next.bytes = {12'd0, count1} << s1.lg;
    clip_next.buf_len = s1.buf_len;
    clip_next.lg = s1.lg;
    clip_next.fixed_disk = s1.fixed_disk;
    case (s1.cls)
      CLS_CAP10: clip_next.lba = ({1'b0, s1.last} > LBA32_MAX) ? LBA32_MAX : {1'b0, s1.last};
      CLS_CAP16: clip_next.lba = {1'b0, s1.last};
      default:   clip_next.lba = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2 <= '0;
    end else begin
      s2 <= clip_next;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/scbr_result.sv
// Third stage: clip to the host buffer and assemble the result word.
`timescale 1ns / 1ps
`default_nettype none
module scbr_result (
  input  wire logic       clk,
  input  wire logic       rst,
  input  scbr_pkg::clip_t s2,
  output scbr_pkg::res_t  s3
);
  import scbr_pkg::*;

  res_t        res_next;
  logic [31:0] count2;
  logic [31:0] xfer_rw;

  always_comb begin
    if (s2.bytes > {12'd0, s2.buf_len}) begin
      count2 = s2.buf_len >> s2.lg;
    end else begin
      count2 = s2.count;
    end
    xfer_rw = count2 << s2.lg;

    res_next = '0;
    res_next.valid = s2.valid;
    res_next.transfer_bytes = s2.buf_len;
    res_next.last_lba = s2.lba;
    case (s2.cls)
      CLS_INVALID: res_next.srb_status = SRB_INVALID;
      CLS_NOT_IMPL: begin
        res_next.srb_status = SRB_INVALID;
        res_next.op_status = OPS_NOT_IMPL;
      end
      CLS_SUCCESS: res_next.srb_status = SRB_SUCCESS;
      CLS_BAD_OP: begin
        res_next.srb_status = SRB_ERROR;
        res_next.op_status = OPS_NOT_IMPL;
      end
      CLS_RW: begin
        res_next.srb_status = SRB_SUCCESS;
        res_next.first_block = s2.start;
        res_next.block_count = count2;
        res_next.transfer_bytes = xfer_rw;
        if (count2 != '0) begin
          res_next.io_mode = s2.is_read ? IO_READ : IO_WRITE;
        end
      end
      CLS_CAP10: begin
        res_next.srb_status = SRB_SUCCESS;
        res_next.info_bytes = CAP10_BYTES;
        res_next.block_size = 13'd1 << s2.lg;
      end
      CLS_CAP16: begin
        res_next.srb_status = SRB_SUCCESS;
        res_next.info_bytes = CAP16_BYTES;
        res_next.block_size = 13'd1 << s2.lg;
      end
      CLS_MODE: begin
        if (s2.buf_len < MODE_HDR_BYTES) begin
          res_next.srb_status = SRB_OVERRUN;
        end else begin
          res_next.srb_status = SRB_SUCCESS;
          res_next.transfer_bytes = MODE_HDR_BYTES;
          res_next.info_bytes = MODE_HDR_BYTES;
          res_next.medium_type = s2.fixed_disk;
        end
      end
      CLS_TOC: begin
        if (s2.buf_len < TOC_BYTES) begin
          res_next.srb_status = SRB_OVERRUN;
          res_next.op_status = OPS_TOO_SMALL;
        end else begin
          res_next.srb_status = SRB_SUCCESS;
          res_next.info_bytes = TOC_BYTES;
        end
      end
      default: res_next.srb_status = SRB_INVALID;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3 <= '0;
    end else begin
      s3 <= res_next;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/scsi_block_command_responder_top.sv
// Top level of the SCSI block command responder: configuration registers and pipeline.
//
// Channel  Direction  Handshake            Word
// command  in         start, busy          req_type, lun, cdb_head, cdb_tail, buffer_bytes
// result   out        done (one cycle)     srb_status .. medium_type
// config   in         cfg_valid, cfg_ready cfg_index, cfg_data
//
// One command is taken in every cycle; busy is always low.
// Each result is on done once its command has passed the decode, clip and result
// register stages in turn.
// Synchronous reset empties the pipeline and restores the register defaults.
// The receiver cannot stall, so results leave in order with no holding.
`timescale 1ns / 1ps
`default_nettype none
module scsi_block_command_responder_top (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [2:0]                       req_type,
  input  wire logic [7:0]                       lun,
  input  wire logic [63:0]                      cdb_head,
  input  wire logic [63:0]                      cdb_tail,
  input  wire logic [31:0]                      buffer_bytes,
  output logic                                  done,
  output logic [1:0]                            srb_status,
  output logic [1:0]                            op_status,
  output logic [1:0]                            io_mode,
  output logic [63:0]                           first_block,
  output logic [31:0]                           block_count,
  output logic [31:0]                           transfer_bytes,
  output logic [31:0]                           info_bytes,
  output logic [63:0]                           last_lba,
  output logic [12:0]                           block_size,
  output logic                                  medium_type,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [scbr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [scbr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import scbr_pkg::*;

  logic [62:0] disk_sectors;
  logic [3:0]  sector_size_log2;
  logic [1:0]  media_kind;
  dec_t        s1;
  clip_t       s2;
  res_t        s3;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      disk_sectors <= DISK_RESET;
      sector_size_log2 <= LOG2_MIN;
      media_kind <= MEDIA_FIXED;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DISK_SECTORS: disk_sectors <= cfg_data[62:0];
        REG_SECTOR_LOG2: sector_size_log2 <= cfg_data[3:0];
        REG_MEDIA_KIND: media_kind <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  scbr_decode u_decode (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (start && !busy),
    .req_type         (req_type),
    .lun              (lun),
    .cdb_head         (cdb_head),
    .cdb_tail         (cdb_tail),
    .buffer_bytes     (buffer_bytes),
    .disk_sectors     (disk_sectors),
    .sector_size_log2 (sector_size_log2),
    .media_kind       (media_kind),
    .s1               (s1)
  );

  scbr_clip u_clip (
    .clk (clk),
    .rst (rst),
    .s1  (s1),
    .s2  (s2)
  );

  scbr_result u_result (
    .clk (clk),
    .rst (rst),
    .s2  (s2),
    .s3  (s3)
  );

  assign done = s3.valid;
  assign srb_status = s3.srb_status;
  assign op_status = s3.op_status;
  assign io_mode = s3.io_mode;
  assign first_block = s3.first_block;
  assign block_count = s3.block_count;
  assign transfer_bytes = s3.transfer_bytes;
  assign info_bytes = s3.info_bytes;
  assign last_lba = s3.last_lba;
  assign block_size = s3.block_size;
  assign medium_type = s3.medium_type;

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("An accepted command did not complete after three cycles.");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 3))
    else $error("A result appeared with no matching command.");

  a_mode_count: assert property (@(posedge clk) disable iff (rst)
    done |-> ((io_mode != IO_NONE) == (block_count != 32'd0)))
    else $error("Transfer direction and block count disagree.");

  a_mode_ok: assert property (@(posedge clk) disable iff (rst)
    (done && io_mode != IO_NONE) |-> (srb_status == SRB_SUCCESS && info_bytes == 32'd0))
    else $error("A data transfer was launched on a failed or reply command.");

endmodule
`default_nettype wire

// File: verif/scsi_block_command_responder_top_test.sv
// Self-checking testbench for the SCSI block command responder top level.
`timescale 1ns / 1ps
module scsi_block_command_responder_top_test;
  import scbr_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 190;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [2:0] REQ_OTHER = 3'd6;
  localparam logic [2:0] REQ_RESERVED = 3'd7;
  localparam logic [7:0] OP_UNKNOWN = 8'hFF;
  localparam logic [62:0] DISK_MAX = '1;

  typedef struct packed {
    logic [2:0]  req;
    logic [7:0]  lun_id;
    logic [63:0] head;
    logic [63:0] tail;
    logic [31:0] host_len;
  } scsi_cmd_t;

  typedef struct packed {
    logic [1:0]  srb;
    logic [1:0]  ops;
    logic [1:0]  io;
    logic [63:0] lba_start;
    logic [31:0] blocks;
    logic [31:0] xfer;
    logic [31:0] info;
    logic [63:0] lba_last;
    logic [12:0] bsize;
    logic        fixed_medium;
  } scsi_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [2:0] req_type = '0;
  logic [7:0] lun = '0;
  logic [63:0] cdb_head = '0;
  logic [63:0] cdb_tail = '0;
  logic [31:0] buffer_bytes = '0;
  logic done;
  logic [1:0] srb_status;
  logic [1:0] op_status;
  logic [1:0] io_mode;
  logic [63:0] first_block;
  logic [31:0] block_count;
  logic [31:0] transfer_bytes;
  logic [31:0] info_bytes;
  logic [63:0] last_lba;
  logic [12:0] block_size;
  logic medium_type;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [62:0] disk_blocks = DISK_RESET;
  logic [3:0] block_log2 = LOG2_MIN;
  logic [1:0] media_class = MEDIA_FIXED;

  scsi_reply_t pending_replies[$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  bit steady_stream = 1'b0;

  always #4 clk = ~clk;

  scsi_block_command_responder_top u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .lun(lun),
    .cdb_head(cdb_head),
    .cdb_tail(cdb_tail),
    .buffer_bytes(buffer_bytes),
    .done(done),
    .srb_status(srb_status),
    .op_status(op_status),
    .io_mode(io_mode),
    .first_block(first_block),
    .block_count(block_count),
    .transfer_bytes(transfer_bytes),
    .info_bytes(info_bytes),
    .last_lba(last_lba),
    .block_size(block_size),
    .medium_type(medium_type),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  function automatic logic [3:0] effective_log2();
    if (block_log2 < LOG2_MIN) return LOG2_MIN;
    if (block_log2 > LOG2_MAX) return LOG2_MAX;
    return block_log2;
  endfunction

  function automatic scsi_reply_t decode_command(scsi_cmd_t c);
    logic [3:0] lg;
    logic [63:0] disk;
    logic [63:0] last;
    logic [63:0] lba;
    logic [63:0] blocks;
    logic [63:0] bytes;
    logic [7:0] opcode;
    scsi_reply_t r;
    lg = effective_log2();
    disk = {1'b0, disk_blocks};
    last = (disk != 0) ? disk - 64'd1 : 64'd0;
    opcode = c.head[63:56];
    r = '0;
    r.srb = SRB_INVALID;
    r.ops = OPS_SUCCESS;
    r.io = IO_NONE;
    r.xfer = c.host_len;
    if (c.lun_id == 8'd0) begin
      case (c.req)
        REQ_EXECUTE: begin
          case (opcode)
            OP_TEST_UNIT_READY, OP_VERIFY10, OP_VERIFY16, OP_MEDIUM_REMOVAL: begin
              r.srb = SRB_SUCCESS;
            end
            OP_READ10, OP_WRITE10, OP_READ16, OP_WRITE16: begin
              if (opcode == OP_READ16 || opcode == OP_WRITE16) begin
                lba = {c.head[47:0], c.tail[63:48]};
                blocks = {32'd0, c.tail[47:16]};
              end else begin
                lba = {32'd0, c.head[47:16]};
                blocks = {48'd0, c.head[7:0], c.tail[63:56]};
              end
              if (lba >= disk) blocks = '0;
              else if (blocks > disk - lba) blocks = disk - lba;
              bytes = blocks << lg;
              if (bytes > {32'd0, c.host_len}) blocks = {32'd0, c.host_len} >> lg;
              bytes = blocks << lg;
              r.lba_start = lba;
              r.blocks = blocks[31:0];
              r.xfer = bytes[31:0];
              r.srb = SRB_SUCCESS;
              if (blocks != 0) begin
                r.io = (opcode == OP_READ10 || opcode == OP_READ16) ? IO_READ : IO_WRITE;
              end
            end
            OP_READ_CAPACITY: begin
              r.lba_last = (last > LBA32_MAX) ? LBA32_MAX : last;
              r.bsize = 13'd1 << lg;
              r.info = CAP10_BYTES;
              r.srb = SRB_SUCCESS;
            end
            OP_READ_CAPACITY16: begin
              r.lba_last = last;
              r.bsize = 13'd1 << lg;
              r.info = CAP16_BYTES;
              r.srb = SRB_SUCCESS;
            end
            OP_MODE_SENSE: begin
              if (c.host_len < MODE_HDR_BYTES) begin
                r.srb = SRB_OVERRUN;
              end else begin
                r.xfer = MODE_HDR_BYTES;
                r.info = MODE_HDR_BYTES;
                r.fixed_medium = (media_class == MEDIA_FIXED);
                r.srb = SRB_SUCCESS;
              end
            end
            OP_READ_TOC: begin
              if (c.host_len < TOC_BYTES) begin
                r.srb = SRB_OVERRUN;
                r.ops = OPS_TOO_SMALL;
              end else begin
                r.info = TOC_BYTES;
                r.srb = SRB_SUCCESS;
              end
            end
            default: begin
              r.srb = SRB_ERROR;
              r.ops = OPS_NOT_IMPL;
            end
          endcase
        end
        REQ_IOCTL, REQ_CLAIM, REQ_RELEASE: begin
        end
        REQ_SHUTDOWN, REQ_FLUSH: begin
          r.srb = SRB_SUCCESS;
        end
        default: begin
          r.ops = OPS_NOT_IMPL;
        end
      endcase
    end
    return r;
  endfunction

  function automatic scsi_cmd_t plain_command(logic [7:0] opcode, logic [31:0] host_len);
    scsi_cmd_t c;
    c.req = REQ_EXECUTE;
    c.lun_id = 8'd0;
    c.head = {$urandom, $urandom};
    c.tail = {$urandom, $urandom};
    c.head[63:56] = opcode;
    c.host_len = host_len;
    return c;
  endfunction

  function automatic scsi_cmd_t rw_command(logic [7:0] opcode, logic [63:0] lba,
                                           logic [31:0] blocks, logic [31:0] host_len);
    scsi_cmd_t c;
    c = plain_command(opcode, host_len);
    if (opcode == OP_READ16 || opcode == OP_WRITE16) begin
      c.head[47:0] = lba[63:16];
      c.tail[63:48] = lba[15:0];
      c.tail[47:16] = blocks;
    end else begin
      c.head[47:16] = lba[31:0];
      c.head[7:0] = blocks[15:8];
      c.tail[63:56] = blocks[7:0];
    end
    return c;
  endfunction

  function automatic scsi_cmd_t random_command();
    scsi_cmd_t c;
    logic [63:0] disk;
    logic [63:0] lba;
    logic [63:0] tmp;
    logic [31:0] blocks;
    logic [31:0] host_len;
    logic [7:0] opcode;
    logic [3:0] lg;
    int pick;
    disk = {1'b0, disk_blocks};
    lg = effective_log2();
    host_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1000) : $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      c.req = 3'($urandom);
      c.lun_id = 8'($urandom);
      c.head = {$urandom, $urandom};
      c.tail = {$urandom, $urandom};
      c.host_len = $urandom;
      return c;
    end
    if (pick < 12) begin
      c = plain_command(OP_TEST_UNIT_READY, host_len);
      c.req = 3'($urandom_range(1, 7));
      return c;
    end
    if (pick < 22) begin
      c = plain_command(8'($urandom), host_len);
      if (pick < 16) c.lun_id = 8'($urandom_range(1, 255));
      return c;
    end
    if (pick >= 60) begin
      case ($urandom_range(0, 7))
        0: opcode = OP_TEST_UNIT_READY;
        1: opcode = OP_VERIFY10;
        2: opcode = OP_VERIFY16;
        3: opcode = OP_MEDIUM_REMOVAL;
        4: opcode = OP_READ_CAPACITY;
        5: opcode = OP_READ_CAPACITY16;
        6: begin
          opcode = OP_MODE_SENSE;
          if ($urandom_range(0, 1) == 0) host_len = $urandom_range(0, 7);
        end
        default: begin
          opcode = OP_READ_TOC;
          if ($urandom_range(0, 1) == 0) host_len = $urandom_range(800, 808);
        end
      endcase
      return plain_command(opcode, host_len);
    end
    case ($urandom_range(0, 3))
      0: opcode = OP_READ10;
      1: opcode = OP_WRITE10;
      2: opcode = OP_READ16;
      default: opcode = OP_WRITE16;
    endcase
    case ($urandom_range(0, 5))
      0: lba = 64'($urandom_range(0, 100));
      1: lba = disk - 64'($urandom_range(0, 20));
      2: lba = disk + 64'($urandom_range(0, 3));
      3: lba = {$urandom, $urandom};
      4: lba = disk >> 1;
      default: lba = '0;
    endcase
    if (opcode == OP_READ10 || opcode == OP_WRITE10) lba[63:32] = '0;
    case ($urandom_range(0, 3))
      0: blocks = '0;
      1: blocks = $urandom_range(1, 64);
      2: blocks = $urandom;
      default: begin
        tmp = disk - lba + 64'($urandom_range(0, 2)) - 64'd1;
        blocks = tmp[31:0];
      end
    endcase
    if (opcode == OP_READ10 || opcode == OP_WRITE10) blocks[31:16] = '0;
    case ($urandom_range(0, 4))
      0: host_len = $urandom;
      1: begin
        tmp = ({32'd0, blocks} << lg) + 64'($urandom_range(0, 2)) - 64'd1;
        host_len = tmp[31:0];
      end
      2: host_len = '0;
      3: host_len = '1;
      default: host_len = $urandom_range(0, 65535);
    endcase
    return rw_command(opcode, lba, blocks, host_len);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic issue_command(scsi_cmd_t c);
    int gap;
    gap = steady_stream ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req_type <= c.req;
    lun <= c.lun_id;
    cdb_head <= c.head;
    cdb_tail <= c.tail;
    buffer_bytes <= c.host_len;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_replies.push_back(decode_command(c));
  endtask

  task automatic wait_replies_drained();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_geometry(logic [63:0] disk_word, logic [63:0] log2_word,
                                logic [63:0] media_word, bit with_unused);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [63:0] words [4];
    int n;
    idx = '{REG_DISK_SECTORS, REG_SECTOR_LOG2, REG_MEDIA_KIND, REG_UNUSED};
    words = '{disk_word, log2_word, media_word, {$urandom, $urandom}};
    n = with_unused ? 4 : 3;
    for (int i = 0; i < n; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= words[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx[i])
        REG_DISK_SECTORS: disk_blocks = words[i][62:0];
        REG_SECTOR_LOG2: block_log2 = words[i][3:0];
        REG_MEDIA_KIND: media_class = words[i][1:0];
        default: begin
        end
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_geometry();
    issue_command(rw_command(OP_READ10, 64'd0, 32'd1, 32'd512));
    issue_command(rw_command(OP_WRITE16, 64'd1, 32'd1, 32'd512));
    issue_command(plain_command(OP_READ_CAPACITY, $urandom));
    issue_command(plain_command(OP_MODE_SENSE, 32'd4));
  endtask

  task automatic test_request_kinds();
    scsi_cmd_t c;
    logic [2:0] kinds [7];
    kinds = '{REQ_IOCTL, REQ_CLAIM, REQ_RELEASE, REQ_SHUTDOWN, REQ_FLUSH, REQ_OTHER,
              REQ_RESERVED};
    foreach (kinds[i]) begin
      c = plain_command(OP_READ10, $urandom);
      c.req = kinds[i];
      issue_command(c);
    end
    c = plain_command(OP_READ10, '1);
    c.lun_id = 8'hFF;
    issue_command(c);
  endtask

  task automatic test_opcodes_and_buffers();
    wait_replies_drained();
    apply_geometry(64'd1000, {60'd0, LOG2_MIN}, 64'd0, 1'b0);
    issue_command(plain_command(OP_TEST_UNIT_READY, $urandom));
    issue_command(plain_command(OP_VERIFY10, $urandom));
    issue_command(plain_command(OP_VERIFY16, $urandom));
    issue_command(plain_command(OP_MEDIUM_REMOVAL, $urandom));
    issue_command(plain_command(OP_UNKNOWN, $urandom));
    issue_command(plain_command(OP_MODE_SENSE, 32'd3));
    issue_command(plain_command(OP_MODE_SENSE, '1));
    issue_command(plain_command(OP_READ_TOC, TOC_BYTES - 32'd1));
    issue_command(plain_command(OP_READ_TOC, TOC_BYTES));
    issue_command(rw_command(OP_READ10, 64'd5, 32'd0, '1));
    issue_command(rw_command(OP_READ10, 64'd990, 32'd100, '1));
    issue_command(rw_command(OP_WRITE10, 64'd0, 32'hFFFF, 32'd1000));
  endtask

  task automatic test_geometry_extremes();
    wait_replies_drained();
    apply_geometry(64'd0, {60'd0, LOG2_MAX}, 64'd2, 1'b1);
    issue_command(rw_command(OP_READ16, 64'd0, 32'd5, '1));
    issue_command(plain_command(OP_READ_CAPACITY16, $urandom));
    wait_replies_drained();
    apply_geometry({1'b1, DISK_MAX}, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    issue_command(plain_command(OP_READ_CAPACITY, $urandom));
    issue_command(plain_command(OP_READ_CAPACITY16, $urandom));
    issue_command(rw_command(OP_WRITE16, {1'b0, DISK_MAX} - 64'd1, '1, '1));
    issue_command(plain_command(OP_MODE_SENSE, 32'd4));
    wait_replies_drained();
    apply_geometry(64'd4096, 64'd0, {62'd0, MEDIA_FIXED}, 1'b0);
    issue_command(plain_command(OP_READ_CAPACITY16, $urandom));
  endtask

  task automatic test_random_traffic();
    logic [63:0] disk_word;
    logic [63:0] log2_word;
    logic [63:0] media_word;
    int stretch;
    stretch = 0;
    for (int p = 0; p < PHASES; p++) begin
      wait_replies_drained();
      disk_word = {$urandom, $urandom};
      case (p)
        0: disk_word[62:0] = DISK_MAX;
        1: disk_word[62:0] = '0;
        2: disk_word[62:0] = 63'd1;
        default: begin
          case ($urandom_range(0, 4))
            0: disk_word[62:0] = 63'($urandom_range(2, 5000));
            1: disk_word[62:0] = 63'h0_FFFF_FFFF + 63'($urandom_range(0, 4)) - 63'd2;
            2: disk_word[62:0] = 63'({$urandom_range(1, 65535), $urandom});
            3: disk_word[62:0] = 63'($urandom);
            default: begin
            end
          endcase
        end
      endcase
      log2_word = {$urandom, $urandom};
      if ($urandom_range(0, 3) != 0) log2_word[3:0] = 4'($urandom_range(9, 12));
      media_word = {$urandom, $urandom};
      apply_geometry(disk_word, log2_word, media_word, $urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        stretch = stretch - 1;
        if (stretch <= 0) begin
          steady_stream = ~steady_stream;
          stretch = $urandom_range(10, 60);
        end
        if ($urandom_range(0, 99) == 0) wait_replies_drained();
        issue_command(random_command());
      end
    end
  endtask

  always @(posedge clk) begin : check_replies
    scsi_reply_t want;
    if (!rst && done) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("result with nothing pending", '0, '0);
      end else begin
        want = pending_replies.pop_front();
        if (srb_status !== want.srb) report_mismatch("srb_status", srb_status, want.srb);
        if (op_status !== want.ops) report_mismatch("op_status", op_status, want.ops);
        if (io_mode !== want.io) report_mismatch("io_mode", io_mode, want.io);
        if (first_block !== want.lba_start)
          report_mismatch("first_block", first_block, want.lba_start);
        if (block_count !== want.blocks)
          report_mismatch("block_count", block_count, want.blocks);
        if (transfer_bytes !== want.xfer)
          report_mismatch("transfer_bytes", transfer_bytes, want.xfer);
        if (info_bytes !== want.info) report_mismatch("info_bytes", info_bytes, want.info);
        if (last_lba !== want.lba_last) report_mismatch("last_lba", last_lba, want.lba_last);
        if (block_size !== want.bsize) report_mismatch("block_size", block_size, want.bsize);
        if (medium_type !== want.fixed_medium)
          report_mismatch("medium_type", medium_type, want.fixed_medium);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_geometry();
    test_request_kinds();
    test_opcodes_and_buffers();
    test_geometry_extremes();
    test_random_traffic();
    wait_replies_drained();
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/scbr_pkg.sv
hw/rtl/scbr_decode.sv
hw/rtl/scbr_clip.sv
hw/rtl/scbr_result.sv
hw/rtl/scsi_block_command_responder_top.sv
verif/scsi_block_command_responder_top_test.sv
